// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, disabled while reset is active
`define SFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SFD_ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SFD_ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/sfd_pkg.sv =====
// types, constants and codes of the sbus frame decoder
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ChanW      = 11;
  localparam int unsigned StickW     = 12;
  localparam int unsigned StoreDepth = 24;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned NumSticks  = 6;
  localparam int unsigned NumLevers  = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 11;

  localparam logic [IdxW-1:0] IdxLast    = 5'd24;
  localparam logic [IdxW-1:0] IdxNoFrame = 5'd25;
  localparam logic [IdxW-1:0] IdxFirst   = 5'd1;

  localparam logic [StickW-1:0] Center = 12'd1024;

  // register reset values
  localparam logic [7:0]         HeaderReset  = 8'd15;
  localparam logic [7:0]         TrailerReset = 8'd0;
  localparam logic [10:0]        MaxMagReset  = 11'd660;
  localparam logic [9:0]         DeadReset    = 10'd10;
  localparam logic signed [10:0] OffsetReset  = 11'sd94;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER   = 3'd0,
    REG_TRAILER  = 3'd1,
    REG_MAX_MAG  = 3'd2,
    REG_DEAD     = 3'd3,
    REG_OFFSET   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED     = 2'd0,
    STATUS_BAD_FRAMING  = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef logic [ByteW-1:0]         byte_t;
  typedef logic signed [StickW-1:0] stick_t;
  typedef logic [ChanW-1:0]         lever_t;
  typedef byte_t [StoreDepth-1:0]   frame_t;

  typedef struct packed {
    logic [7:0]         header_value;
    logic [7:0]         trailer_value;
    logic [10:0]        max_magnitude;
    logic [9:0]         dead_band;
    logic signed [10:0] third_offset;
  } cfg_t;

  typedef struct packed {
    logic at_last;     // next plain byte closes the frame
    logic frame_done;  // closing byte transferred this cycle
  } cap_status_t;

  typedef struct packed {
    stick_t [NumSticks-1:0] sticks;
    lever_t [NumLevers-1:0] levers;
    logic                   online;
    logic                   framing_ok;
    logic                   range_ok;
  } decode_t;

endpackage

// ===== rtl/sfd_in_if.sv =====
// byte input channel
`timescale 1ns / 1ps

interface sfd_in_if;
  import sfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/sfd_out_if.sv =====
// frame result channel
`timescale 1ns / 1ps

interface sfd_out_if;
  import sfd_pkg::*;

  logic        valid;
  logic        ready;
  stick_t      stick_one;
  stick_t      stick_two;
  stick_t      stick_three;
  stick_t      stick_four;
  stick_t      knob_one;
  stick_t      knob_two;
  lever_t      lever_one;
  lever_t      lever_two;
  lever_t      lever_three;
  lever_t      lever_four;
  logic        link_online;
  logic [1:0]  frame_status;

  modport source (
    output valid, input ready,
    output stick_one, output stick_two, output stick_three, output stick_four,
    output knob_one, output knob_two,
    output lever_one, output lever_two, output lever_three, output lever_four,
    output link_online, output frame_status
  );
  modport sink (
    input valid, output ready,
    input stick_one, input stick_two, input stick_three, input stick_four,
    input knob_one, input knob_two,
    input lever_one, input lever_two, input lever_three, input lever_four,
    input link_online, input frame_status
  );
endinterface

// ===== rtl/sfd_cfg_if.sv =====
// configuration write channel
`timescale 1ns / 1ps

interface sfd_cfg_if;
  import sfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/sfd_cfg_regs.sv =====
// configuration register file
`timescale 1ns / 1ps

module sfd_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  sfd_cfg_if.sink        cfg_ch,
  output sfd_pkg::cfg_t  cfg
);
  import sfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_HEADER:  cfg_nxt.header_value  = cfg_ch.wr_data[7:0];
        REG_TRAILER: cfg_nxt.trailer_value = cfg_ch.wr_data[7:0];
        REG_MAX_MAG: cfg_nxt.max_magnitude = cfg_ch.wr_data[10:0];
        REG_DEAD:    cfg_nxt.dead_band     = cfg_ch.wr_data[9:0];
        REG_OFFSET:  cfg_nxt.third_offset  = $signed(cfg_ch.wr_data[10:0]);
        default:     cfg_nxt = cfg_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value  <= HeaderReset;
      cfg_r.trailer_value <= TrailerReset;
      cfg_r.max_magnitude <= MaxMagReset;
      cfg_r.dead_band     <= DeadReset;
      cfg_r.third_offset  <= OffsetReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/sfd_frame_capture.sv =====
// byte counter and frame byte store
`timescale 1ns / 1ps

module sfd_frame_capture (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  sfd_pkg::byte_t       rx_byte,
  input  logic                 frame_start,
  output sfd_pkg::frame_t      frame,
  output sfd_pkg::cap_status_t cap
);
  import sfd_pkg::*;

  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] idx_nxt;
  frame_t          store_r;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;

  assign cap.at_last    = (idx_r == IdxLast);
  assign cap.frame_done = accept && !frame_start && (idx_r == IdxLast);
  assign frame          = store_r;

  always_comb begin
    idx_nxt = idx_r;
    wr_en   = 1'b0;
    wr_idx  = idx_r;
    if (accept) begin
      if (frame_start) begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        idx_nxt = IdxFirst;
      end else if (idx_r < IdxLast) begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + IdxFirst;
      end else if (idx_r == IdxLast) begin
        idx_nxt = IdxNoFrame;  // trailer byte is decoded, not stored
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IdxNoFrame;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= rx_byte;
    end
  end

endmodule

// ===== rtl/sfd_channel_decode.sv =====
// channel unpack, centring, trim, deadband and range check, plus framing and online flags
`timescale 1ns / 1ps

module sfd_channel_decode (
  input  sfd_pkg::frame_t  frame,
  input  sfd_pkg::byte_t   trailer,
  input  sfd_pkg::cfg_t    cfg,
  output sfd_pkg::decode_t dec
);
  import sfd_pkg::*;

  lever_t [NumSticks-1:0]  raw;
  stick_t [NumSticks-1:0]  centred;
  logic   [StickW-1:0]     mag    [NumSticks];
  logic   [NumSticks-1:0]  in_dead;
  logic   [NumSticks-1:0]  lane_ok;
  stick_t                  trim;

  assign raw[0] = {frame[2][2:0], frame[1]};
  assign raw[1] = {frame[3][5:0], frame[2][7:3]};
  assign raw[2] = {frame[5][0],   frame[4], frame[3][7:6]};
  assign raw[3] = {frame[6][3:0], frame[5][7:1]};
  assign raw[4] = {frame[7][6:0], frame[6][7:4]};
  assign raw[5] = {frame[9][1:0], frame[8], frame[7][7]};

  assign dec.levers[0] = {frame[10][4:0], frame[9][7:2]};
  assign dec.levers[1] = {frame[11],      frame[10][7:5]};
  assign dec.levers[2] = {frame[13][2:0], frame[12]};
  assign dec.levers[3] = {frame[14][5:0], frame[13][7:3]};

  assign dec.online     = (frame[23][3:2] == 2'b00);
  assign dec.framing_ok = (frame[0] == cfg.header_value) && (trailer == cfg.trailer_value);

  assign trim = {cfg.third_offset[10], cfg.third_offset};

  always_comb begin
    for (int k = 0; k < NumSticks; k++) begin
      centred[k] = $signed({1'b0, raw[k]} - Center);
      if (k == 2) begin
        centred[k] = centred[k] + trim;
      end
      mag[k]     = centred[k][StickW-1] ? (~centred[k] + 12'd1) : centred[k];
      in_dead[k] = (mag[k] <= {2'b00, cfg.dead_band});
      lane_ok[k] = in_dead[k] || (mag[k] <= {1'b0, cfg.max_magnitude});
      dec.sticks[k] = in_dead[k] ? '0 : centred[k];
    end
  end

  assign dec.range_ok = &lane_ok;

endmodule

// ===== rtl/sbus_frame_decoder_unit.sv =====
// top level of the sbus frame decoder
//
//  channel  | dir | payload                                          | transfer when
//  ---------+-----+--------------------------------------------------+------------------
//  in_ch    | in  | rx_byte[7:0], frame_start                        | valid && ready
//  out_ch   | out | 6 sticks/knobs, 4 levers, link_online, status    | valid && ready
//  cfg_ch   | in  | reg_index[2:0], wr_data[10:0]                    | valid (ready = 1)
//
// one byte is taken per cycle unless stalled; the frame store and byte counter
// are the input registers, the closing byte is decoded in the same cycle, the
// result is shown the next cycle from the published snapshot and status register
// reset (rst_n low, synchronous) closes any open frame, zeroes the snapshot
// and loads the register defaults; the frame store itself is not cleared
// a waiting result stalls any byte that arrives while the open frame lacks
// only its closing byte (a restart included); other bytes keep flowing, and
// the stalled byte goes through in the cycle the waiting result is taken
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbus_frame_decoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch,
  sfd_cfg_if.sink   cfg_ch
);
  import sfd_pkg::*;

  cfg_t        cfg;
  frame_t      frame;
  cap_status_t cap;
  decode_t     dec;
  logic        in_accept;
  logic        done_fire;

  // published snapshot and result status
  stick_t [NumSticks-1:0] pub_sticks_r;
  lever_t [NumLevers-1:0] pub_levers_r;
  logic                   pub_online_r;
  status_t                status_r;
  status_t                status_nxt;
  logic                   out_valid_r;
  logic                   publish;

  sfd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // only the closing byte needs room in the result register
  assign in_ch.ready = !cap.at_last || !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  sfd_frame_capture u_cap (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .frame       (frame),
    .cap         (cap)
  );

  // trailer byte comes straight off the input channel
  sfd_channel_decode u_dec (
    .frame   (frame),
    .trailer (in_ch.rx_byte),
    .cfg     (cfg),
    .dec     (dec)
  );

  assign done_fire = cap.frame_done;
  assign publish   = done_fire && dec.framing_ok && dec.range_ok;

  // bad framing wins over out of range
  always_comb begin
    if (!dec.framing_ok) begin
      status_nxt = STATUS_BAD_FRAMING;
    end else if (!dec.range_ok) begin
      status_nxt = STATUS_OUT_OF_RANGE;
    end else begin
      status_nxt = STATUS_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_sticks_r <= '0;
      pub_levers_r <= '0;
      pub_online_r <= 1'b0;
      out_valid_r  <= 1'b0;
      status_r     <= STATUS_ACCEPTED;
    end else begin
      if (publish) begin
        pub_sticks_r <= dec.sticks;
        pub_levers_r <= dec.levers;
        pub_online_r <= dec.online;
      end
      if (done_fire) begin
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // the snapshot only moves when a closing byte is taken, which is held
  // back while a result waits, so it doubles as the output register
  assign out_ch.valid        = out_valid_r;
  assign out_ch.stick_one    = pub_sticks_r[0];
  assign out_ch.stick_two    = pub_sticks_r[1];
  assign out_ch.stick_three  = pub_sticks_r[2];
  assign out_ch.stick_four   = pub_sticks_r[3];
  assign out_ch.knob_one     = pub_sticks_r[4];
  assign out_ch.knob_two     = pub_sticks_r[5];
  assign out_ch.lever_one    = pub_levers_r[0];
  assign out_ch.lever_two    = pub_levers_r[1];
  assign out_ch.lever_three  = pub_levers_r[2];
  assign out_ch.lever_four   = pub_levers_r[3];
  assign out_ch.link_online  = pub_online_r;
  assign out_ch.frame_status = status_r;

  // a new result never overwrites one that is still waiting
  `SFD_ASSERT_CLK(a_no_overwrite, clk, rst_n, done_fire |-> (!out_valid_r || out_ch.ready), "result overwritten while waiting")
  // every closed frame shows a result the next cycle
  `SFD_ASSERT_CLK(a_done_shows, clk, rst_n, done_fire |=> out_valid_r, "closed frame gave no result")
  // snapshot stays put unless a frame is closed
  `SFD_ASSERT_CLK(a_snap_hold, clk, rst_n, !done_fire |=> ($stable(pub_sticks_r) && $stable(pub_levers_r) && $stable(pub_online_r)), "snapshot changed without a frame")
  // closing a frame leaves no frame open
  `SFD_ASSERT_CLK(a_frame_closed, clk, rst_n, done_fire |=> !cap.at_last, "frame still open after closing byte")

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the sbus frame decoder unit
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  // one decoded frame as seen on the result channel
  typedef struct {
    stick_t     sticks [6];
    lever_t     levers [4];
    logic       online;
    logic [1:0] status;
  } snapshot_t;

  // directed stimulus rows
  typedef enum logic [1:0] {
    ROW_FRAME,  // one complete frame
    ROW_STRAY,  // single byte without frame_start
    ROW_CUT     // first cut_at bytes of the frame, then the frame again from its start
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    byte_t             header;   // also the byte of a stray row
    byte_t             trailer;
    byte_t             flags;    // frame byte 23
    logic [0:5][10:0]  raw;      // raw stick and knob channels
    logic [0:3][10:0]  levers;
    logic [4:0]        cut_at;
    logic              typed;    // expected result given below instead of predicted
    status_t           want_status;
    logic [0:5][11:0]  want_sticks;
    logic [0:3][10:0]  want_levers;
    logic              want_online;
  } dir_row_t;

  localparam int NumRows    = 14;
  localparam int NumPhases  = 6;
  localparam int PhaseBytes = 200;

  localparam logic [0:5][10:0] Mid6 = {6{11'd1024}};

  // with the reset settings: header 0x0f, trailer 0x00, limit 660, dead band 10, trim 94
  localparam dir_row_t DirRows [NumRows] = '{
    // byte with no open frame is dropped, both extremes
    '{ROW_STRAY, 8'hFF, 8'h00, 8'h00, Mid6, '0, 5'd0, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    '{ROW_STRAY, 8'h00, 8'h00, 8'h00, Mid6, '0, 5'd0, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    // bad header, snapshot still the reset one
    '{ROW_FRAME, 8'hF0, 8'h00, 8'h00, Mid6, '0, 5'd0, 1'b1, STATUS_BAD_FRAMING, '0, '0, 1'b0},
    // bad trailer
    '{ROW_FRAME, 8'h0F, 8'hFF, 8'h00, Mid6, '0, 5'd0, 1'b1, STATUS_BAD_FRAMING, '0, '0, 1'b0},
    // bad header wins over channels out of range
    '{ROW_FRAME, 8'h00, 8'h00, 8'hFF,
      {11'd0, 11'd2047, 11'd0, 11'd2047, 11'd0, 11'd2047}, {4{11'd2047}}, 5'd0, 1'b1,
      STATUS_BAD_FRAMING, '0, '0, 1'b0},
    // good framing, stick one at +1023
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h00, {11'd2047, {5{11'd1024}}}, '0, 5'd0, 1'b1,
      STATUS_OUT_OF_RANGE, '0, '0, 1'b0},
    // all centred, only the trim shows on channel three
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h00, Mid6, {11'd0, 11'd2047, 11'h555, 11'h2AA}, 5'd0, 1'b1,
      STATUS_ACCEPTED, {12'd0, 12'd0, 12'd94, 12'd0, 12'd0, 12'd0},
      {11'd0, 11'd2047, 11'h555, 11'h2AA}, 1'b1},
    // restart inside a frame, dead band edges, trim cancels channel three, both flags set
    '{ROW_CUT, 8'h0F, 8'h00, 8'h0C,
      {11'd1034, 11'd1014, 11'd930, 11'd1035, 11'd1013, 11'd1024},
      {11'd1, 11'd2, 11'd3, 11'd4}, 5'd10, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    // exactly at the magnitude limit, trimmed channel three at -660, lost flag
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h04,
      {11'd1684, 11'd364, 11'd270, {3{11'd1024}}}, {4{11'd2047}}, 5'd0, 1'b0,
      STATUS_ACCEPTED, '0, '0, 1'b0},
    // one past the limit on knob two, snapshot kept
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h00, {{5{11'd1024}}, 11'd1685}, '0, 5'd0, 1'b0,
      STATUS_ACCEPTED, '0, '0, 1'b0},
    // trimmed channel three far negative
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h00, {11'd1024, 11'd1024, 11'd0, {3{11'd1024}}}, '0, 5'd0,
      1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    // extra byte after a closed frame
    '{ROW_STRAY, 8'hA5, 8'h00, 8'h00, Mid6, '0, 5'd0, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    // mixed values, failsafe flag
    '{ROW_FRAME, 8'h0F, 8'h00, 8'h08,
      {11'd1500, 11'd600, 11'd1200, 11'd1100, 11'd900, 11'd1300},
      {11'd100, 11'd200, 11'd300, 11'd400}, 5'd0, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0},
    '{ROW_STRAY, 8'h5A, 8'h00, 8'h00, Mid6, '0, 5'd0, 1'b0, STATUS_ACCEPTED, '0, '0, 1'b0}
  };

  // register settings of the random phases, extremes first
  localparam cfg_t Settings [NumPhases] = '{
    '{8'h00, 8'hFF, 11'd2047, 10'd0, 11'h400},      // trim -1024
    '{8'hFF, 8'h00, 11'd0, 10'd1023, 11'sd1023},
    '{8'h0F, 8'h00, 11'd660, 10'd10, 11'sd94},
    '{8'hA5, 8'h5A, 11'd1000, 10'd300, -11'sd200},
    '{8'h3C, 8'hC3, 11'd1500, 10'd1, 11'sd0},
    '{8'h0F, 8'h00, 11'd700, 10'd50, 11'sd500}
  };

  logic clk;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();
  sfd_cfg_if cfg_ch ();

  sbus_frame_decoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder mirror: registers, byte counter, frame store and published snapshot
  byte_t              want_header;
  byte_t              want_trailer;
  logic [10:0]        mag_limit;
  logic [9:0]         dead_zone;
  logic signed [10:0] trim;
  logic [4:0]         frame_pos;
  byte_t              frame_store [StoreDepth];
  stick_t             pub_sticks [6];
  lever_t             pub_levers [4];
  logic               pub_online;

  snapshot_t snapshots_due [$];
  int        mismatches = 0;

  // directed rows with a typed-in result override the mirror for their one frame
  logic      typed_pending = 1'b0;
  snapshot_t typed_want;

  int    send_idle_pct;
  int    recv_idle_pct;
  byte_t frame_buf [25];

  string stick_names [6] = '{"stick_one", "stick_two", "stick_three", "stick_four",
                             "knob_one", "knob_two"};
  string lever_names [4] = '{"lever_one", "lever_two", "lever_three", "lever_four"};

  // feed one byte to the mirror; returns 1 when the byte closes a frame
  function automatic bit decode_rx_byte(byte_t b, logic start, output snapshot_t res);
    logic [175:0] chan_bits;
    stick_t       fresh [6];
    int           centred;
    int           mag;
    bit           in_range;
    logic [1:0]   status;

    if (start) begin
      frame_store[0] = b;
      frame_pos = IdxFirst;
      return 1'b0;
    end
    if (frame_pos < IdxLast) begin
      frame_store[frame_pos] = b;
      frame_pos = frame_pos + 5'd1;
      return 1'b0;
    end
    // counter saturated: byte dropped
    if (frame_pos != IdxLast) return 1'b0;
    frame_pos = IdxNoFrame;

    status = STATUS_ACCEPTED;
    if (frame_store[0] != want_header || b != want_trailer) begin
      status = STATUS_BAD_FRAMING;
    end else begin
      // bytes 1..22 form one little-endian stream of 11-bit channels
      for (int i = 0; i < 22; i++) chan_bits[8*i +: 8] = frame_store[i+1];
      in_range = 1'b1;
      for (int k = 0; k < 6; k++) begin
        centred = int'(chan_bits[11*k +: 11]) - int'(Center);
        if (k == 2) centred += int'(trim);
        mag = (centred < 0) ? -centred : centred;
        if (mag <= int'(dead_zone)) begin
          centred = 0;
          mag = 0;
        end
        if (mag > int'(mag_limit)) in_range = 1'b0;
        fresh[k] = stick_t'(centred);
      end
      if (in_range) begin
        pub_sticks = fresh;
        for (int j = 0; j < 4; j++) pub_levers[j] = chan_bits[11*(6+j) +: 11];
        // lost and failsafe bits of the flags byte
        pub_online = ~|frame_store[23][3:2];
      end else begin
        status = STATUS_OUT_OF_RANGE;
      end
    end

    res.sticks = pub_sticks;
    res.levers = pub_levers;
    res.online = pub_online;
    res.status = status;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mirror update and scoreboard, all on sampled values at the rising edge
  always @(posedge clk) begin : watch
    snapshot_t got;
    snapshot_t want;

    if (!rst_n) begin
      want_header  = HeaderReset;
      want_trailer = TrailerReset;
      mag_limit    = MaxMagReset;
      dead_zone    = DeadReset;
      trim         = OffsetReset;
      frame_pos    = IdxNoFrame;
      pub_online   = 1'b0;
      for (int k = 0; k < 6; k++) pub_sticks[k] = '0;
      for (int j = 0; j < 4; j++) pub_levers[j] = '0;
    end else begin
      // result transfer first: it is always older than a byte taken in the same cycle
      if (out_ch.valid && out_ch.ready) begin
        got.sticks[0] = out_ch.stick_one;
        got.sticks[1] = out_ch.stick_two;
        got.sticks[2] = out_ch.stick_three;
        got.sticks[3] = out_ch.stick_four;
        got.sticks[4] = out_ch.knob_one;
        got.sticks[5] = out_ch.knob_two;
        got.levers[0] = out_ch.lever_one;
        got.levers[1] = out_ch.lever_two;
        got.levers[2] = out_ch.lever_three;
        got.levers[3] = out_ch.lever_four;
        got.online    = out_ch.link_online;
        got.status    = out_ch.frame_status;
        if (snapshots_due.size() == 0) begin
          $error("result transfer with no frame outstanding");
          mismatches++;
        end else begin
          want = snapshots_due.pop_front();
          for (int k = 0; k < 6; k++) check_field(stick_names[k], want.sticks[k], got.sticks[k]);
          for (int j = 0; j < 4; j++) check_field(lever_names[j], want.levers[j], got.levers[j]);
          check_field("link_online", want.online, got.online);
          check_field("frame_status", want.status, got.status);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (decode_rx_byte(in_ch.rx_byte, in_ch.frame_start, want))
          snapshots_due.push_back(typed_pending ? typed_want : want);
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.reg_index))
          REG_HEADER:  want_header  = cfg_ch.wr_data[7:0];
          REG_TRAILER: want_trailer = cfg_ch.wr_data[7:0];
          REG_MAX_MAG: mag_limit    = cfg_ch.wr_data;
          REG_DEAD:    dead_zone    = cfg_ch.wr_data[9:0];
          REG_OFFSET:  trim         = cfg_ch.wr_data;
          default: ;
        endcase
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one byte transfer; returns on the falling edge after it, valid left high
  task automatic send_byte(byte_t b, logic start);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.rx_byte     = b;
    in_ch.frame_start = start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
  endtask

  // lay out header, 16 channels, flags and trailer as on the wire
  function automatic void pack_frame(byte_t hdr, byte_t trl, byte_t flags,
                                     logic [15:0][10:0] chans);
    logic [175:0] chan_bits;

    chan_bits = chans;
    frame_buf[0] = hdr;
    for (int i = 0; i < 22; i++) frame_buf[i+1] = chan_bits[8*i +: 8];
    frame_buf[23] = flags;
    frame_buf[24] = trl;
  endfunction

  // wait for every outstanding result, then a few cycles more
  task automatic drain();
    in_ch.valid = 1'b0;
    while (snapshots_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] data);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wr_data   = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t          row;
    cfg_t              setting;
    logic [15:0][10:0] chans;
    byte_t             hdr;
    byte_t             trl;
    int                phase_bytes;
    int                choice;
    int                pick;
    int                centred;
    int                raw;
    int                n;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.wr_data    = '0;
    send_idle_pct     = 6;
    recv_idle_pct     = 68;

    // hold reset low, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows at the reset settings
    for (int r = 0; r < NumRows; r++) begin
      row = DirRows[r];
      if (row.kind == ROW_STRAY) begin
        send_byte(row.header, 1'b0);
      end else begin
        for (int k = 0; k < 16; k++) begin
          if (k < 6) chans[k] = row.raw[k];
          else if (k < 10) chans[k] = row.levers[k-6];
          else chans[k] = 11'($urandom);
        end
        pack_frame(row.header, row.trailer, row.flags, chans);
        if (row.kind == ROW_CUT) send_frame(row.cut_at);
        for (int k = 0; k < 6; k++) typed_want.sticks[k] = row.want_sticks[k];
        for (int j = 0; j < 4; j++) typed_want.levers[j] = row.want_levers[j];
        typed_want.online = row.want_online;
        typed_want.status = row.want_status;
        typed_pending = row.typed;
        send_frame(25);
        typed_pending = 1'b0;
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      // sender lightly idle, receiver mostly stalled; then swapped; then full rate
      case (phase / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      drain();
      setting = Settings[phase];
      write_reg(REG_HEADER, CfgDataW'(setting.header_value));
      write_reg(REG_TRAILER, CfgDataW'(setting.trailer_value));
      write_reg(REG_MAX_MAG, setting.max_magnitude);
      write_reg(REG_DEAD, CfgDataW'(setting.dead_band));
      write_reg(REG_OFFSET, setting.third_offset);

      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        choice = $urandom_range(0, 99);
        if (choice < 8) begin
          // line noise, now and then a spurious start
          repeat ($urandom_range(1, 6)) begin
            send_byte(byte_t'($urandom), $urandom_range(0, 9) == 0);
            phase_bytes++;
          end
        end else begin
          // stick and knob channels clustered on the dead band and limit edges of this setting
          for (int k = 0; k < 16; k++) begin
            if (k < 6) begin
              pick = $urandom_range(0, 9);
              if (pick < 2) centred = $urandom_range(0, 2047) - 1024;
              else if (pick < 4) centred = int'(dead_zone) + $urandom_range(0, 2) - 1;
              else if (pick < 6) centred = int'(mag_limit) + $urandom_range(0, 2) - 1;
              else centred = $urandom_range(0, int'(mag_limit));
              if ($urandom_range(0, 1) == 1) centred = -centred;
              raw = centred + 1024 - ((k == 2) ? int'(trim) : 0);
              if (raw < 0 || raw > 2047) raw = $urandom_range(0, 2047);
              chans[k] = raw[10:0];
            end else begin
              chans[k] = 11'($urandom);
            end
          end
          hdr = ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : want_header;
          trl = ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : want_trailer;
          pack_frame(hdr, trl, byte_t'($urandom), chans);
          // some frames are broken off and restarted by the next one
          n = (choice < 16) ? $urandom_range(1, 24) : 25;
          send_frame(n);
          phase_bytes += n;
          if (n == 25 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              send_byte(byte_t'($urandom), 1'b0);
              phase_bytes++;
            end
          end
        end
      end
    end

    drain();
    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
